// ===== rtl/one_wire_bus_master_defines.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

// Checked on every rising edge while reset is low.
`define OWB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define OWB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/owb_pkg.sv =====
package owb_pkg;

   localparam int CSR_COUNT        = 8;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int TICK_WIDTH       = 10;
   localparam int DATA_WIDTH       = 8;
   localparam int BIT_INDEX_WIDTH  = 3;
   localparam int CMD_QUEUE_DEPTH  = 2;
   localparam int RSP_QUEUE_DEPTH  = 2;

   localparam logic [TICK_WIDTH-1:0] WRITE_ZERO_RELEASE = 10'd5;

   localparam logic [TICK_WIDTH-1:0] CSR_RESET_VALUES [CSR_COUNT] = '{
      10'd10, 10'd55, 10'd65, 10'd10, 10'd53, 10'd1000, 10'd100, 10'd410
   };

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_WRITE_ONE_LOW     = 3'd0,
      CSR_WRITE_ONE_RELEASE = 3'd1,
      CSR_WRITE_ZERO_LOW    = 3'd2,
      CSR_READ_SAMPLE_WAIT  = 3'd3,
      CSR_READ_RECOVER      = 3'd4,
      CSR_RESET_LOW         = 3'd5,
      CSR_PRESENCE_WAIT     = 3'd6,
      CSR_RESET_RECOVER     = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_RESET = 3'd1,
      OP_WBIT  = 3'd2,
      OP_RBIT  = 3'd3,
      OP_WBYTE = 3'd4,
      OP_RBYTE = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_LOW     = 3'd1,
      PH_WAIT    = 3'd2,
      PH_SAMPLE  = 3'd3,
      PH_RECOVER = 3'd4
   } phase_type;

   typedef struct packed {
      logic [2:0]            op;
      logic [DATA_WIDTH-1:0] write_data;
      logic                  line_in;
   } req_type;

   typedef struct packed {
      logic                  drive_low;
      logic                  busy_res;
      logic                  done_res;
      logic [DATA_WIDTH-1:0] read_data;
      logic                  presence_line;
      logic                  rejected;
   } rsp_type;

   typedef struct packed {
      logic                  is_cmd;
      op_type                kind;
      logic [DATA_WIDTH-1:0] shift_init;
      logic                  line_in;
   } cmd_type;

   typedef struct packed {
      logic                       valid;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [TICK_WIDTH-1:0]      data;
   } csr_write_type;

endpackage

// ===== rtl/owb_front.sv =====
module owb_front (
   input  owb_pkg::req_type req_data,
   output owb_pkg::cmd_type cmd
);
   import owb_pkg::*;

   always_comb begin
      cmd.line_in    = req_data.line_in;
      cmd.is_cmd     = 1'b1;
      cmd.kind       = OP_TICK;
      cmd.shift_init = '0;
      unique case (req_data.op)
         OP_RESET: begin
            cmd.kind = OP_RESET;
         end
         OP_WBIT: begin
            cmd.kind       = OP_WBIT;
            cmd.shift_init = {{(DATA_WIDTH-1){1'b0}}, req_data.write_data[0]};
         end
         OP_RBIT: begin
            cmd.kind = OP_RBIT;
         end
         OP_WBYTE: begin
            cmd.kind       = OP_WBYTE;
            cmd.shift_init = req_data.write_data;
         end
         OP_RBYTE: begin
            cmd.kind = OP_RBYTE;
         end
         default: begin
            cmd.is_cmd = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/owb_fifo.sv =====
module owb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);
   localparam int PTR_WIDTH   = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]   LAST_PTR  = PTR_WIDTH'(DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(DEPTH);

   logic [WIDTH-1:0]       mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/owb_engine.sv =====
module owb_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  owb_pkg::cmd_type       cmd,
   input  owb_pkg::csr_write_type csr_write,
   output owb_pkg::rsp_type       rsp
);
   import owb_pkg::*;

   logic [TICK_WIDTH-1:0]      cfg_ff [CSR_COUNT];
   logic [TICK_WIDTH-1:0]      cfg_eff [CSR_COUNT];

   phase_type                  phase_ff, phase_in, eff_phase;
   logic [TICK_WIDTH-1:0]      tick_ff, tick_in, eff_tick, tick_dec;
   logic [BIT_INDEX_WIDTH-1:0] bit_idx_ff, bit_idx_in, eff_bit_idx, next_bit_idx;
   logic [DATA_WIDTH-1:0]      shift_ff, shift_in, eff_shift;
   op_type                     kind_ff, kind_in, eff_kind;
   logic                       presence_ff, presence_in;
   logic                       eff_is_write, eff_cur_bit, start_is_write;
   logic                       slot_end, cmd_done;

   always_comb begin
      for (int i = 0; i < CSR_COUNT; i++) begin
         cfg_eff[i] = (cfg_ff[i] == '0) ? TICK_WIDTH'(1) : cfg_ff[i];
      end
   end

   always_comb begin
      eff_phase      = phase_ff;
      eff_tick       = tick_ff;
      eff_bit_idx    = bit_idx_ff;
      eff_shift      = shift_ff;
      eff_kind       = kind_ff;
      start_is_write = (cmd.kind == OP_WBIT) || (cmd.kind == OP_WBYTE);
      if (phase_ff == PH_IDLE && cmd.is_cmd) begin
         eff_phase   = PH_LOW;
         eff_bit_idx = '0;
         eff_shift   = cmd.shift_init;
         eff_kind    = cmd.kind;
         if (cmd.kind == OP_RESET) begin
            eff_tick = cfg_eff[CSR_RESET_LOW];
         end else if (start_is_write) begin
            eff_tick = cmd.shift_init[0] ? cfg_eff[CSR_WRITE_ONE_LOW]
                                         : cfg_eff[CSR_WRITE_ZERO_LOW];
         end else begin
            eff_tick = TICK_WIDTH'(1);
         end
      end
      eff_is_write = (eff_kind == OP_WBIT) || (eff_kind == OP_WBYTE);
      eff_cur_bit  = eff_shift[eff_bit_idx];
      next_bit_idx = eff_bit_idx + 1'b1;
   end

   always_comb begin
      phase_in    = eff_phase;
      tick_in     = eff_tick;
      bit_idx_in  = eff_bit_idx;
      shift_in    = eff_shift;
      kind_in     = eff_kind;
      presence_in = presence_ff;
      tick_dec    = eff_tick - 1'b1;
      slot_end    = 1'b0;
      cmd_done    = 1'b0;
      unique case (eff_phase)
         PH_IDLE: begin
         end
         PH_LOW: begin
            tick_in = tick_dec;
            if (tick_dec == '0) begin
               if (eff_kind == OP_RESET) begin
                  phase_in = PH_WAIT;
                  tick_in  = cfg_eff[CSR_PRESENCE_WAIT];
               end else if (eff_is_write) begin
                  phase_in = PH_RECOVER;
                  tick_in  = eff_cur_bit ? cfg_eff[CSR_WRITE_ONE_RELEASE]
                                         : WRITE_ZERO_RELEASE;
               end else begin
                  phase_in = PH_WAIT;
                  tick_in  = cfg_eff[CSR_READ_SAMPLE_WAIT];
               end
            end
         end
         PH_WAIT: begin
            tick_in = tick_dec;
            if (tick_dec == '0) begin
               phase_in = PH_SAMPLE;
            end
         end
         PH_SAMPLE: begin
            if (eff_kind == OP_RESET) begin
               presence_in = cmd.line_in;
               tick_in     = cfg_eff[CSR_RESET_RECOVER] - 1'b1;
            end else begin
               if (cmd.line_in) begin
                  shift_in[eff_bit_idx] = 1'b1;
               end
               tick_in = cfg_eff[CSR_READ_RECOVER] - 1'b1;
            end
            if (tick_in == '0) begin
               slot_end = 1'b1;
            end else begin
               phase_in = PH_RECOVER;
            end
         end
         PH_RECOVER: begin
            tick_in = tick_dec;
            if (tick_dec == '0) begin
               slot_end = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      if (slot_end) begin
         if (eff_kind == OP_WBYTE || eff_kind == OP_RBYTE) begin
            cmd_done = (eff_bit_idx == '1);
         end else begin
            cmd_done = 1'b1;
         end
         if (cmd_done) begin
            phase_in = PH_IDLE;
            tick_in  = '0;
         end else begin
            bit_idx_in = next_bit_idx;
            phase_in   = PH_LOW;
            if (eff_is_write) begin
               tick_in = eff_shift[next_bit_idx] ? cfg_eff[CSR_WRITE_ONE_LOW]
                                                 : cfg_eff[CSR_WRITE_ZERO_LOW];
            end else begin
               tick_in = TICK_WIDTH'(1);
            end
         end
      end
   end

   always_comb begin
      rsp.drive_low     = (eff_phase == PH_LOW);
      rsp.busy_res      = (eff_phase != PH_IDLE);
      rsp.done_res      = cmd_done;
      rsp.read_data     = '0;
      rsp.presence_line = presence_in;
      rsp.rejected      = (phase_ff != PH_IDLE) && cmd.is_cmd;
      if (cmd_done && (eff_kind == OP_RBIT || eff_kind == OP_RBYTE)) begin
         rsp.read_data = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tick_ff     <= '0;
         bit_idx_ff  <= '0;
         shift_ff    <= '0;
         kind_ff     <= OP_TICK;
         presence_ff <= 1'b1;
      end else if (step) begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         bit_idx_ff  <= bit_idx_in;
         shift_ff    <= shift_in;
         kind_ff     <= kind_in;
         presence_ff <= presence_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSR_COUNT; i++) begin
            cfg_ff[i] <= CSR_RESET_VALUES[i];
         end
      end else if (csr_write.valid) begin
         cfg_ff[csr_write.index] <= csr_write.data;
      end
   end

endmodule

// ===== rtl/one_wire_bus_master.sv =====
// 1-Wire bus master driven by microsecond ticks. Every item pushed on the req_ side is one
// tick and yields exactly one item on the rsp_ side, carrying the drive level, busy, done,
// read data, the last presence level and a reject flag. Items pass through a short command
// queue into the timing engine and then through a result queue; while that queue has room
// the engine handles one tick per clock cycle, a sustained rate of one item per cycle. Both
// queues are registered. The eight timing registers are written through the csr_ port,
// which is always ready; they should only change while no command is running.
module one_wire_bus_master #(
   parameter int CMD_DEPTH = owb_pkg::CMD_QUEUE_DEPTH,
   parameter int RSP_DEPTH = owb_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  owb_pkg::req_type                    req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output owb_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [owb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [owb_pkg::TICK_WIDTH-1:0]      csr_data
);
   import owb_pkg::*;

   cmd_type       front_cmd, queued_cmd;
   rsp_type       engine_rsp;
   csr_write_type csr_write;
   logic          cmd_empty, rsp_full, step;

   assign csr_ready       = 1'b1;
   assign csr_write.valid = csr_valid && csr_ready;
   assign csr_write.index = csr_index;
   assign csr_write.data  = csr_data;
   assign step            = !cmd_empty && !rsp_full;

   owb_front u_front (
      .req_data (req_data),
      .cmd      (front_cmd)
   );

   owb_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .wr_data (front_cmd),
      .pop     (step),
      .empty   (cmd_empty),
      .rd_data (queued_cmd)
   );

   owb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .cmd       (queued_cmd),
      .csr_write (csr_write),
      .rsp       (engine_rsp)
   );

   owb_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (step),
      .full    (rsp_full),
      .wr_data (engine_rsp),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_data)
   );

endmodule

// ===== rtl/owb_checker.sv =====
`include "one_wire_bus_master_defines.svh"

module owb_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input owb_pkg::rsp_type rsp_data
);

   `OWB_ASSERT(a_done_is_busy, (!rsp_empty && rsp_data.done_res) |-> rsp_data.busy_res, "done without busy")
   `OWB_ASSERT(a_reject_is_busy, (!rsp_empty && rsp_data.rejected) |-> rsp_data.busy_res, "reject while idle")
   `OWB_ASSERT(a_read_on_done, (!rsp_empty && rsp_data.read_data != '0) |-> rsp_data.done_res, "read data off done")
   `OWB_ASSERT(a_result_held, (!rsp_empty && !rsp_pop) |=> !rsp_empty, "waiting item lost")
   `OWB_ASSERT_ALWAYS(a_reset_empties, reset |=> rsp_empty, "results after reset")

endmodule

bind one_wire_bus_master owb_checker u_owb_checker (.*);

// ===== verif/tb_one_wire_bus_master.sv =====
`default_nettype none

module tb_one_wire_bus_master;
   timeunit 1ns;
   timeprecision 1ps;

   import owb_pkg::*;

   localparam logic [2:0] OP_UNDEF_LO = 3'd6;
   localparam logic [2:0] OP_UNDEF_HI = 3'd7;

   localparam int LINE_LOW    = 0;
   localparam int LINE_HIGH   = 1;
   localparam int LINE_RANDOM = 2;

   localparam int RANDOM_PHASES   = 3;
   localparam int PHASE_ITEMS     = 80;
   localparam int HOLD_START      = 100;
   localparam int HOLD_CYCLES     = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          req_push = 1'b0;
   logic          req_full;
   req_type       req_data = '0;
   logic          rsp_empty;
   logic          rsp_pop = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_WRITE_ONE_LOW;
   logic [TICK_WIDTH-1:0] csr_data = '0;

   one_wire_bus_master dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5ns clock = ~clock;

   // Shadow of the bus engine, advanced once per accepted item.
   logic [TICK_WIDTH-1:0] timing_reg [CSR_COUNT] = CSR_RESET_VALUES;
   phase_type             bus_phase  = PH_IDLE;
   logic [TICK_WIDTH-1:0] ticks_left = '0;
   logic [2:0]            bit_pos    = '0;
   logic [7:0]            shift_reg  = '0;
   op_type                cmd_kind   = OP_TICK;
   logic                  presence   = 1'b1;

   req_type tick_queue[$];
   rsp_type predicted_outputs[$];
   int      queued_count   = 0;
   int      accepted_count = 0;
   int      failures       = 0;

   int          burst_left = 0;
   int          gap_left   = 0;
   logic [15:0] pop_mask   = '1;
   int          mask_age   = 0;
   int          cycle_count = 0;
   int          hold_left   = 0;

   function automatic logic [TICK_WIDTH-1:0] slot_ticks(csr_index_type idx);
      return (timing_reg[idx] == '0) ? 10'd1 : timing_reg[idx];
   endfunction

   function automatic void begin_slot();
      bus_phase = PH_LOW;
      if (cmd_kind == OP_RESET) begin
         ticks_left = slot_ticks(CSR_RESET_LOW);
      end else if (cmd_kind == OP_WBIT || cmd_kind == OP_WBYTE) begin
         ticks_left = shift_reg[bit_pos] ? slot_ticks(CSR_WRITE_ONE_LOW)
                                         : slot_ticks(CSR_WRITE_ZERO_LOW);
      end else begin
         ticks_left = 10'd1;
      end
   endfunction

   function automatic rsp_type advance_bus(req_type r);
      rsp_type o;
      logic    is_cmd;
      logic    finished;
      o = '0;
      finished = 1'b0;
      is_cmd = (r.op >= OP_RESET) && (r.op <= OP_RBYTE);
      if (bus_phase == PH_IDLE) begin
         if (is_cmd) begin
            cmd_kind = op_type'(r.op);
            bit_pos = '0;
            if (r.op == OP_WBYTE) begin
               shift_reg = r.write_data;
            end else if (r.op == OP_WBIT) begin
               shift_reg = {7'd0, r.write_data[0]};
            end else begin
               shift_reg = '0;
            end
            begin_slot();
         end
      end else if (is_cmd) begin
         o.rejected = 1'b1;
      end
      if (bus_phase != PH_IDLE) begin
         o.busy_res = 1'b1;
         case (bus_phase)
            PH_LOW: begin
               o.drive_low = 1'b1;
               ticks_left = ticks_left - 10'd1;
               if (ticks_left == '0) begin
                  if (cmd_kind == OP_RESET) begin
                     bus_phase = PH_WAIT;
                     ticks_left = slot_ticks(CSR_PRESENCE_WAIT);
                  end else if (cmd_kind == OP_WBIT || cmd_kind == OP_WBYTE) begin
                     bus_phase = PH_RECOVER;
                     ticks_left = shift_reg[bit_pos] ? slot_ticks(CSR_WRITE_ONE_RELEASE)
                                                     : WRITE_ZERO_RELEASE;
                  end else begin
                     bus_phase = PH_WAIT;
                     ticks_left = slot_ticks(CSR_READ_SAMPLE_WAIT);
                  end
               end
            end
            PH_WAIT: begin
               ticks_left = ticks_left - 10'd1;
               if (ticks_left == '0) begin
                  bus_phase = PH_SAMPLE;
               end
            end
            PH_SAMPLE: begin
               if (cmd_kind == OP_RESET) begin
                  presence = r.line_in;
                  ticks_left = slot_ticks(CSR_RESET_RECOVER) - 10'd1;
               end else begin
                  if (r.line_in) begin
                     shift_reg[bit_pos] = 1'b1;
                  end
                  ticks_left = slot_ticks(CSR_READ_RECOVER) - 10'd1;
               end
               if (ticks_left == '0) begin
                  finished = 1'b1;
               end else begin
                  bus_phase = PH_RECOVER;
               end
            end
            default: begin
               ticks_left = ticks_left - 10'd1;
               if (ticks_left == '0) begin
                  finished = 1'b1;
               end
            end
         endcase
         if (finished) begin
            bus_phase = PH_IDLE;
            ticks_left = '0;
            if (cmd_kind == OP_RESET || cmd_kind == OP_WBIT || cmd_kind == OP_RBIT ||
                bit_pos == 3'd7) begin
               o.done_res = 1'b1;
               if (cmd_kind == OP_RBIT || cmd_kind == OP_RBYTE) begin
                  o.read_data = shift_reg;
               end
            end else begin
               bit_pos = bit_pos + 3'd1;
               begin_slot();
            end
         end
      end
      o.presence_line = presence;
      return o;
   endfunction

   // Number of ticks a command takes when it starts on an idle bus.
   function automatic int command_ticks(op_type op, logic [7:0] data);
      int n;
      int b;
      n = 0;
      case (op)
         OP_RESET: begin
            n = int'(slot_ticks(CSR_RESET_LOW)) + int'(slot_ticks(CSR_PRESENCE_WAIT)) +
                int'(slot_ticks(CSR_RESET_RECOVER));
         end
         OP_RBIT, OP_RBYTE: begin
            n = 1 + int'(slot_ticks(CSR_READ_SAMPLE_WAIT)) +
                int'(slot_ticks(CSR_READ_RECOVER));
            if (op == OP_RBYTE) begin
               n = n * 8;
            end
         end
         OP_WBIT, OP_WBYTE: begin
            for (b = 0; b < ((op == OP_WBYTE) ? 8 : 1); b++) begin
               if (data[b]) begin
                  n += int'(slot_ticks(CSR_WRITE_ONE_LOW)) +
                       int'(slot_ticks(CSR_WRITE_ONE_RELEASE));
               end else begin
                  n += int'(slot_ticks(CSR_WRITE_ZERO_LOW)) + int'(WRITE_ZERO_RELEASE);
               end
            end
         end
         default: n = 1;
      endcase
      return n;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      failures++;
   endtask

   task automatic check_output(rsp_type got);
      rsp_type want;
      if (predicted_outputs.size() == 0) begin
         report_mismatch("unexpected item", int'(got), 0);
      end else begin
         want = predicted_outputs.pop_front();
         if (got.drive_low !== want.drive_low)
            report_mismatch("drive_low", int'(got.drive_low), int'(want.drive_low));
         if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
         if (got.done_res !== want.done_res)
            report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
         if (got.read_data !== want.read_data)
            report_mismatch("read_data", int'(got.read_data), int'(want.read_data));
         if (got.presence_line !== want.presence_line)
            report_mismatch("presence_line", int'(got.presence_line),
                            int'(want.presence_line));
         if (got.rejected !== want.rejected)
            report_mismatch("rejected", int'(got.rejected), int'(want.rejected));
      end
   endtask

   task automatic add_item(logic [2:0] op, logic [7:0] data, int line_mode);
      req_type r;
      r.op = op;
      r.write_data = data;
      r.line_in = (line_mode == LINE_RANDOM) ? 1'($urandom_range(0, 1))
                                             : (line_mode == LINE_HIGH);
      tick_queue.push_back(r);
      queued_count++;
   endtask

   function automatic op_type random_command();
      return op_type'($urandom_range(OP_RESET, OP_RBYTE));
   endfunction

   // A command followed by the ticks that carry it to its done tick. Stray commands
   // land while the bus is busy; with poke_done one lands on the done tick itself.
   task automatic queue_command(op_type op, logic [7:0] data, int line_mode, int stray,
                                bit poke_done);
      int len;
      int i;
      len = command_ticks(op, data);
      add_item(op, data, line_mode);
      for (i = 1; i < len; i++) begin
         if ((poke_done && i == len - 1) || (stray > 0 && $urandom_range(1, stray) == 1)) begin
            add_item(random_command(), 8'($urandom), line_mode);
         end else if ($urandom_range(0, 9) == 0) begin
            add_item($urandom_range(0, 1) ? OP_UNDEF_LO : OP_UNDEF_HI, 8'($urandom),
                     line_mode);
         end else begin
            add_item(OP_TICK, 8'($urandom), line_mode);
         end
      end
   endtask

   task automatic wait_quiet();
      do @(posedge clock);
      while (accepted_count != queued_count || predicted_outputs.size() != 0);
   endtask

   task automatic settle_bus();
      int i;
      wait_quiet();
      while (bus_phase != PH_IDLE) begin
         for (i = 0; i < 32; i++) begin
            add_item(OP_TICK, 8'($urandom), LINE_RANDOM);
         end
         wait_quiet();
      end
   endtask

   task automatic write_timing(csr_index_type idx, logic [TICK_WIDTH-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      timing_reg[idx] = value;
   endtask

   task automatic write_all_timing(logic [TICK_WIDTH-1:0] value);
      int i;
      for (i = 0; i < CSR_COUNT; i++) begin
         write_timing(csr_index_type'(i), value);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predicted_outputs.push_back(advance_bus(req_data));
            accepted_count++;
         end
         if (!req_push || !req_full) begin
            if (burst_left == 0) begin
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               burst_left = $urandom_range(1, 32);
            end
            if (gap_left > 0 || tick_queue.size() == 0) begin
               if (gap_left > 0) begin
                  gap_left--;
               end
               req_push <= 1'b0;
            end else begin
               req_push <= 1'b1;
               req_data <= tick_queue.pop_front();
               burst_left--;
            end
         end
      end
   end

   // One long receiver hold-off so the block fills up and pushes back.
   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
         hold_left <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count == HOLD_START) begin
            hold_left <= HOLD_CYCLES;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_output(rsp_data);
         end
         rsp_pop <= pop_mask[0] && hold_left == 0;
         if (mask_age == 0) begin
            case ($urandom_range(0, 3))
               0: pop_mask <= '1;
               1: pop_mask <= 16'($urandom);
               2: pop_mask <= 16'($urandom | $urandom);
               default: pop_mask <= 16'($urandom & $urandom) | 16'h1;
            endcase
            mask_age <= 64;
         end else begin
            pop_mask <= {pop_mask[0], pop_mask[15:1]};
            mask_age <= mask_age - 1;
         end
      end
   end

   initial begin
      int p;
      int i;
      int target;
      logic [TICK_WIDTH-1:0] value;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Power-up timing: bit commands, undefined ops and a reject on the done tick.
      add_item(OP_UNDEF_LO, 8'hFF, LINE_HIGH);
      add_item(OP_UNDEF_HI, 8'h00, LINE_LOW);
      add_item(OP_TICK, 8'h55, LINE_RANDOM);
      queue_command(OP_WBIT, 8'hFE, LINE_RANDOM, 0, 1'b0);
      queue_command(OP_WBIT, 8'h01, LINE_RANDOM, 0, 1'b0);
      queue_command(OP_RBIT, 8'h00, LINE_HIGH, 0, 1'b1);
      settle_bus();

      // All registers zero, which the block treats as one.
      write_all_timing('0);
      queue_command(OP_RESET, 8'h00, LINE_HIGH, 0, 1'b0);
      queue_command(OP_RESET, 8'h00, LINE_LOW, 0, 1'b0);
      queue_command(OP_WBYTE, 8'h00, LINE_RANDOM, 0, 1'b0);
      queue_command(OP_WBYTE, 8'hFF, LINE_RANDOM, 0, 1'b1);
      queue_command(OP_RBYTE, 8'h00, LINE_RANDOM, 0, 1'b0);
      queue_command(OP_RBIT, 8'h00, LINE_LOW, 0, 1'b0);
      queue_command(OP_WBIT, 8'h01, LINE_RANDOM, 0, 1'b0);
      settle_bus();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         for (i = 0; i < CSR_COUNT; i++) begin
            case ($urandom_range(0, 9))
               0: value = '0;
               1: value = 10'($urandom_range(13, 60));
               default: value = 10'($urandom_range(1, 12));
            endcase
            write_timing(csr_index_type'(i), value);
         end
         target = queued_count + PHASE_ITEMS;
         while (queued_count < target) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(1, 4)) begin
                  add_item(3'($urandom_range(0, 7)), 8'($urandom), LINE_RANDOM);
               end
            end else begin
               queue_command(random_command(), 8'($urandom), LINE_RANDOM, 12,
                             $urandom_range(0, 5) == 0);
            end
         end
         settle_bus();
      end

      wait_quiet();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("** one_wire_bus_master: PASSED **");
      end else begin
         $display("** one_wire_bus_master: FAILED **");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("** one_wire_bus_master: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
